>>> rtl/core/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off during reset
`define RGBBMP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication into the next cycle, off during reset
`define RGBBMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// implication into the next cycle, active during reset
`define RGBBMP_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset assertion failed");

`endif

>>> rtl/core/rgbbmp_pkg.sv
// shared types, constants and helpers of the rgb565 to bmp24 encoder
`default_nettype none
package rgbbmp_pkg;

  localparam int CFG_W       = 13;
  localparam int PIX_W       = 16;
  localparam int MAX_DIM_DEF = 4096;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd320;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd240;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [7:0] HDR_LEN  = 8'd54;
  localparam logic [7:0] INFO_LEN = 8'd40;
  localparam logic [7:0] BPP      = 8'd24;
  localparam logic [5:0] HDR_LAST = 6'd53;

  localparam int ROWB_W = CFG_W + 2;
  localparam int PROD_W = ROWB_W + CFG_W;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             hdr;
    logic [1:0]       pad;
    logic             img_end;
  } cmd_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input int maxd);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > maxd) begin
      r = CFG_W'(maxd);
    end
    return r;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [5:0] idx,
                                          input logic [CFG_W-1:0] w,
                                          input logic [CFG_W-1:0] h,
                                          input logic [31:0] fsz);
    logic [15:0] w16;
    logic [15:0] h16;
    logic [7:0]  b;
    w16 = 16'(w);
    h16 = 16'(h);
    unique case (idx)
      6'd0:    b = 8'h42;
      6'd1:    b = 8'h4D;
      6'd2:    b = fsz[7:0];
      6'd3:    b = fsz[15:8];
      6'd4:    b = fsz[23:16];
      6'd5:    b = fsz[31:24];
      6'd10:   b = HDR_LEN;
      6'd14:   b = INFO_LEN;
      6'd18:   b = w16[7:0];
      6'd19:   b = w16[15:8];
      6'd22:   b = h16[7:0];
      6'd23:   b = h16[15:8];
      6'd26:   b = 8'd1;
      6'd28:   b = BPP;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/rgbbmp_front.sv
// front end: takes pixels, tracks row and column, builds one command per pixel
`default_nettype none
module rgbbmp_front import rgbbmp_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire logic [PIX_W-1:0] in_pixel_word,
  output logic                  in_full,
  input  wire logic [CFG_W-1:0] cfg_width,
  input  wire logic [CFG_W-1:0] cfg_height,
  input  wire logic             q_full,
  output logic                  q_push,
  output cmd_t                  q_data
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  logic [CNT_W-1:0] column_r, column_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic             hdr_sent_r, hdr_sent_nxt;
  logic [CFG_W-1:0] w_eff, h_eff;
  logic             accept, row_end, img_end;

  assign w_eff   = clamp_dim(cfg_width, MAX_DIM);
  assign h_eff   = clamp_dim(cfg_height, MAX_DIM);
  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  assign row_end = (CMP_W'(column_r) + CMP_W'(1)) >= CMP_W'(w_eff);
  assign img_end = row_end && ((CMP_W'(row_r) + CMP_W'(1)) >= CMP_W'(h_eff));

  always_comb begin
    column_nxt   = column_r;
    row_nxt      = row_r;
    hdr_sent_nxt = hdr_sent_r;
    if (accept) begin
      hdr_sent_nxt = !img_end;
      if (row_end) begin
        column_nxt = '0;
        row_nxt    = img_end ? '0 : row_r + CNT_W'(1);
      end else begin
        column_nxt = column_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      row_r      <= '0;
      hdr_sent_r <= 1'b0;
    end else begin
      column_r   <= column_nxt;
      row_r      <= row_nxt;
      hdr_sent_r <= hdr_sent_nxt;
    end
  end

  assign q_push         = accept;
  assign q_data.pix     = {in_pixel_word[7:0], in_pixel_word[15:8]};
  assign q_data.hdr     = !hdr_sent_r;
  assign q_data.pad     = row_end ? w_eff[1:0] : 2'd0;
  assign q_data.img_end = img_end;

endmodule
`default_nettype wire

>>> rtl/core/rgbbmp_cmdq.sv
// small command queue between the front and back ends
`default_nettype none
module rgbbmp_cmdq import rgbbmp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      wdata,
  output logic      full,
  input  wire logic pop,
  output cmd_t      rdata,
  output logic      empty
);

  cmd_t                  mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_PTR_W:0]   cnt_r;
  logic                  do_push, do_pop;

  assign full    = cnt_r == (CMDQ_PTR_W+1)'(CMDQ_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + CMDQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (CMDQ_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (CMDQ_PTR_W+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rgbbmp_back.sv
// back end: expands commands into header, pixel and pad bytes
`default_nettype none
module rgbbmp_back import rgbbmp_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CFG_W-1:0] cfg_width,
  input  wire logic [CFG_W-1:0] cfg_height,
  input  wire logic             q_empty,
  input  cmd_t                  q_data,
  output logic                  q_pop,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output logic [7:0]            out_byte,
  output logic                  out_run_last,
  output logic                  out_image_done
);

  localparam logic [1:0] ST_HDR = 2'd0;
  localparam logic [1:0] ST_PIX = 2'd1;
  localparam logic [1:0] ST_PAD = 2'd2;

  logic [CFG_W-1:0]  w_eff, h_eff;
  logic [ROWB_W-1:0] rowb_r;
  logic [CFG_W-1:0]  h_r;
  logic [PROD_W-1:0] prod_r;
  logic [31:0]       fsz;

  cmd_t       cmd_r, cmd_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] st_r, st_nxt;
  logic [5:0] idx_r, idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_done_r, out_done_nxt;

  logic       emit, fin, load;
  logic [7:0] cur_byte;

  assign w_eff = clamp_dim(cfg_width, MAX_DIM);
  assign h_eff = clamp_dim(cfg_height, MAX_DIM);

  // file size: 54 + (3w + pad) * h, registered through rowb_r and h_r, then prod_r
  always_ff @(posedge clk) begin
    rowb_r <= ROWB_W'(w_eff) * ROWB_W'(3) + ROWB_W'(w_eff[1:0]);
    h_r    <= h_eff;
    prod_r <= PROD_W'(rowb_r) * PROD_W'(h_r);
  end
  assign fsz = 32'(prod_r) + 32'(HDR_LEN);

  assign emit = busy_r && (!out_valid_r || out_pop);

  always_comb begin
    cur_byte = 8'd0;
    fin      = 1'b0;
    unique case (st_r)
      ST_HDR: cur_byte = hdr_byte(idx_r, w_eff, h_eff, fsz);
      ST_PIX: begin
        case (idx_r[1:0])
          2'd0:    cur_byte = {cmd_r.pix[4:0], 3'b000};
          2'd1:    cur_byte = {cmd_r.pix[10:5], 2'b00};
          default: cur_byte = {cmd_r.pix[15:11], 3'b000};
        endcase
        fin = (idx_r[1:0] == 2'd2) && (cmd_r.pad == 2'd0);
      end
      ST_PAD: fin = idx_r[1:0] == (cmd_r.pad - 2'd1);
      default: begin
        cur_byte = 8'd0;
        fin      = 1'b0;
      end
    endcase
  end

  assign load  = !q_empty && (!busy_r || (emit && fin));
  assign q_pop = load;

  always_comb begin
    cmd_nxt  = cmd_r;
    busy_nxt = busy_r;
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    if (emit) begin
      idx_nxt = idx_r + 6'd1;
      unique case (st_r)
        ST_HDR: begin
          if (idx_r == HDR_LAST) begin
            st_nxt  = ST_PIX;
            idx_nxt = '0;
          end
        end
        ST_PIX: begin
          if (idx_r[1:0] == 2'd2) begin
            st_nxt  = ST_PAD;
            idx_nxt = '0;
          end
        end
        ST_PAD: ;
        default: st_nxt = ST_PIX;
      endcase
      if (fin) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      cmd_nxt  = q_data;
      busy_nxt = 1'b1;
      st_nxt   = q_data.hdr ? ST_HDR : ST_PIX;
      idx_nxt  = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_pop;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = fin;
      out_done_nxt  = fin && cmd_r.img_end;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      st_r        <= ST_HDR;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_run_last   = out_last_r;
  assign out_image_done = out_done_r;

endmodule
`default_nettype wire

>>> rtl/core/rgb565_to_bmp24_stream_encoder.sv
// top level of the rgb565 to 24-bit bmp stream encoder
`default_nettype none
// Takes one byte-swapped RGB565 pixel per item, pixels in BMP order, and
// produces the 24-bit BMP file one byte per result item. The first pixel of
// each image is preceded by the 54-byte header; each pixel gives B, G, R;
// the last pixel of a row is followed by 0 to 3 zero pad bytes. The output
// register moves one byte per cycle unless the receiver stalls it; a
// pixel gives three bytes, plus its pad bytes at a row end and the header
// at the image start. A four-entry command queue lets pixels be taken
// while bytes drain. The header file size comes from a registered multiply
// (rowb_r and h_r, then prod_r). No clearing pass follows reset.
module rgb565_to_bmp24_stream_encoder import rgbbmp_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire logic [PIX_W-1:0] in_pixel_word,
  output logic                  in_full,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output logic [7:0]            out_byte,
  output logic                  out_run_last,
  output logic                  out_image_done,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] width_r, height_r;
  logic             q_push, q_full, q_pop, q_empty;
  cmd_t             q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
        CFG_IDX_HEIGHT: height_r <= cfg_wdata;
        default:        width_r  <= width_r;
      endcase
    end
  end

  rgbbmp_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_pixel_word (in_pixel_word),
    .in_full       (in_full),
    .cfg_width     (width_r),
    .cfg_height    (height_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  rgbbmp_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  rgbbmp_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_width      (width_r),
    .cfg_height     (height_r),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_image_done (out_image_done)
  );

endmodule
`default_nettype wire

>>> rtl/core/rgbbmp_checker.sv
// port-level checker of the encoder and its bind
`default_nettype none
`include "assert_macros.svh"
module rgbbmp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_full,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [7:0] out_byte,
  input wire logic       out_run_last,
  input wire logic       out_image_done
);

  `RGBBMP_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_byte))
  `RGBBMP_ASSERT_NOW(a_done_is_last, !out_empty && out_image_done, out_run_last)
  `RGBBMP_ASSERT_RESET(a_reset_clears, !rst_n, out_empty && !in_full)

endmodule

bind rgb565_to_bmp24_stream_encoder rgbbmp_checker u_chk (.*);
`default_nettype wire

>>> sim/rgb565_to_bmp24_stream_encoder_tb.sv
// self-checking testbench for the rgb565 to bmp24 stream encoder
module rgb565_to_bmp24_stream_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rgbbmp_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 31;
  localparam int N_DIRECTED    = 22;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       image_done;
  } file_byte_t;

  typedef enum logic {ROW_PIXEL, ROW_DIMS} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [PIX_W-1:0] pix;
    logic [CFG_W-1:0] w_val;
    logic [CFG_W-1:0] h_val;
    bit               typed;
    logic [23:0]      bgr;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic [PIX_W-1:0] in_pixel_word = '0;
  logic             in_full;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic [7:0]       out_byte;
  logic             out_run_last;
  logic             out_image_done;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_IDX_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  file_byte_t expected_bytes [$];
  int err_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;

  // encoder state as seen by the predictor
  logic [CFG_W-1:0] width_reg = WIDTH_RST;
  logic [CFG_W-1:0] height_reg = HEIGHT_RST;
  int col_pos = 0;
  int row_pos = 0;
  bit header_out = 1'b0;

  // bgr typed in only where it is plain from the pixel word
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_PIXEL, 16'h0000, '0, '0, 1'b1, 24'h000000},
    '{ROW_PIXEL, 16'hFFFF, '0, '0, 1'b1, 24'hF8FCF8},
    '{ROW_DIMS,  '0, 13'd1, 13'd1, 1'b0, '0},
    '{ROW_PIXEL, 16'hE007, '0, '0, 1'b1, 24'h00FC00},
    '{ROW_DIMS,  '0, 13'd0, 13'd0, 1'b0, '0},
    '{ROW_PIXEL, 16'h00F8, '0, '0, 1'b1, 24'h0000F8},
    '{ROW_DIMS,  '0, 13'd8191, 13'd4096, 1'b0, '0},
    '{ROW_PIXEL, 16'h1F00, '0, '0, 1'b1, 24'hF80000},
    '{ROW_DIMS,  '0, 13'd2, 13'd2, 1'b0, '0},
    '{ROW_PIXEL, 16'h1234, '0, '0, 1'b0, '0},
    '{ROW_PIXEL, 16'hABCD, '0, '0, 1'b0, '0},
    '{ROW_PIXEL, 16'h5A5A, '0, '0, 1'b0, '0},
    '{ROW_PIXEL, 16'hA5A5, '0, '0, 1'b0, '0},
    '{ROW_DIMS,  '0, 13'd3, 13'd1, 1'b0, '0},
    '{ROW_PIXEL, 16'h0F0F, '0, '0, 1'b0, '0},
    '{ROW_PIXEL, 16'hF0F0, '0, '0, 1'b0, '0},
    '{ROW_PIXEL, 16'h3C3C, '0, '0, 1'b0, '0},
    '{ROW_DIMS,  '0, 13'd4, 13'd1, 1'b0, '0},
    '{ROW_PIXEL, 16'h8001, '0, '0, 1'b0, '0},
    '{ROW_PIXEL, 16'h7FFE, '0, '0, 1'b0, '0},
    '{ROW_PIXEL, 16'h5555, '0, '0, 1'b0, '0},
    '{ROW_PIXEL, 16'hAAAA, '0, '0, 1'b0, '0}
  };

  rgb565_to_bmp24_stream_encoder uut (.*);

  always #5 clk = ~clk;

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("FAIL rgb565_to_bmp24_stream_encoder");
    $finish;
  end

  function automatic int used_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(v);
  endfunction

  task automatic flag_error(input string msg);
    if (err_count < 100) $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  // file bytes caused by one pixel, appended to the expected stream
  task automatic encode_pixel(input logic [PIX_W-1:0] raw, input bit typed,
                              input logic [23:0] typed_bgr);
    int w;
    int h;
    int pad;
    logic [15:0] p;
    logic [31:0] fsz;
    logic [7:0] hdr [54];
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    bit img_end;
    file_byte_t run [$];
    w = used_dim(width_reg);
    h = used_dim(height_reg);
    pad = (4 - (w * 3) % 4) % 4;
    p = {raw[7:0], raw[15:8]};
    if (!header_out) begin
      fsz = 32'(longint'(HDR_LEN) + longint'(w * 3 + pad) * longint'(h));
      foreach (hdr[i]) hdr[i] = 8'd0;
      hdr[0] = 8'h42;
      hdr[1] = 8'h4D;
      {hdr[5], hdr[4], hdr[3], hdr[2]} = fsz;
      hdr[10] = HDR_LEN;
      hdr[14] = INFO_LEN;
      {hdr[19], hdr[18]} = 16'(w);
      {hdr[23], hdr[22]} = 16'(h);
      hdr[26] = 8'd1;
      hdr[28] = BPP;
      foreach (hdr[i]) run.push_back({hdr[i], 2'b00});
      header_out = 1'b1;
    end
    b = {p[4:0], 3'b000};
    g = {p[10:5], 2'b00};
    r = {p[15:11], 3'b000};
    if (typed) {b, g, r} = typed_bgr;
    run.push_back({b, 2'b00});
    run.push_back({g, 2'b00});
    run.push_back({r, 2'b00});
    img_end = 1'b0;
    if (col_pos + 1 >= w) begin
      repeat (pad) run.push_back({8'd0, 2'b00});
      col_pos = 0;
      img_end = (row_pos + 1 >= h);
      if (img_end) begin
        row_pos = 0;
        header_out = 1'b0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    run[run.size() - 1].run_last = 1'b1;
    run[run.size() - 1].image_done = img_end;
    foreach (run[i]) expected_bytes.push_back(run[i]);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] word, input bit typed,
                            input logic [23:0] typed_bgr);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_pixel_word <= word;
    do @(posedge clk); while (in_full);
    encode_pixel(word, typed, typed_bgr);
  endtask

  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_dims(input bit set_w, input bit set_h,
                          input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val);
    drain();
    if (set_w) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_WIDTH;
      cfg_wdata <= w_val;
      width_reg = w_val;
      @(negedge clk);
    end
    if (set_h) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_HEIGHT;
      cfg_wdata <= h_val;
      height_reg = h_val;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    file_byte_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_bytes.size() == 0) begin
        flag_error($sformatf("unexpected byte %02h", out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data)
          flag_error($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
        if (out_run_last !== want.run_last)
          flag_error($sformatf("out_run_last %b, expected %b", out_run_last, want.run_last));
        if (out_image_done !== want.image_done)
          flag_error($sformatf("out_image_done %b, expected %b",
                               out_image_done, want.image_done));
      end
    end
  end

  initial begin
    int kind;
    bit pick;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_DIMS) begin
        set_dims(1'b1, 1'b1, directed_rows[i].w_val, directed_rows[i].h_val);
      end else begin
        send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].bgr);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        set_dims(1'b1, 1'b1, CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 4)));
      end else if (kind == 7) begin
        set_dims(1'b1, 1'b1, CFG_W'($urandom_range(9, 8191)), CFG_W'($urandom_range(1, 3)));
      end else if (kind == 8) begin
        // one register only, usually mid-image
        pick = 1'($urandom_range(0, 1));
        set_dims(pick, !pick, CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 4)));
      end else begin
        set_dims(1'b1, 1'b1, CFG_W'($urandom_range(0, 8191)), CFG_W'($urandom_range(0, 8191)));
      end
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
        default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
      endcase
      // long receiver hold-off so the input side backs up
      if (ph == 0) hold_left = HOLD_CYCLES;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == PHASE_ITEMS / 2) drain();
        send_pixel(PIX_W'($urandom_range(0, 65535)), 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("PASS rgb565_to_bmp24_stream_encoder");
    end else begin
      $display("FAIL rgb565_to_bmp24_stream_encoder");
    end
    $finish;
  end

endmodule
